// File: hdl/pfe_pkg.sv
// shared types and constants for the postfix expression evaluator
// used by pfe_front, pfe_fifo, pfe_div, pfe_back, the top level and the testbench; no dependencies
package pfe_pkg;

   localparam int DATA_W      = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;

   localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_LEFTOVER = 2'd1;
   localparam logic [1:0] STATUS_DIVZERO  = 2'd2;

   typedef enum logic [2:0] {
      OP_NONE = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4
   } op_type;

   // one classified request: optional finished operand, optional operator, end mark
   typedef struct packed {
      logic              has_num;
      logic [DATA_W-1:0] num;
      op_type            op;
      logic              last;
   } token_type;

endpackage

// File: hdl/pfe_front.sv
// front end: accumulates decimal operands and classifies each request into a token
// depends on pfe_pkg
module pfe_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          character,
   input  logic                last,
   output logic                tok_valid,
   output pfe_pkg::token_type  tok
);
   import pfe_pkg::*;

   logic [DATA_W-1:0] acc_ff, acc_in, acc_next;
   logic              in_num_ff, in_num_in;
   logic              is_digit;
   op_type            op;

   always_comb begin
      is_digit = (character >= CH_ZERO) && (character <= CH_NINE);
      case (character)
         CH_PLUS:  op = OP_ADD;
         CH_MINUS: op = OP_SUB;
         CH_STAR:  op = OP_MUL;
         CH_SLASH: op = OP_DIV;
         default:  op = OP_NONE;
      endcase
      // acc * 10 + digit, wrapping
      acc_next = (in_num_ff ? ((acc_ff << 3) + (acc_ff << 1)) : '0)
                 + DATA_W'(character - CH_ZERO);
      acc_in    = acc_ff;
      in_num_in = in_num_ff;
      tok       = '{has_num: 1'b0, num: acc_ff, op: OP_NONE, last: last};
      tok_valid = 1'b0;
      if (is_digit) begin
         if (last) begin
            tok       = '{has_num: 1'b1, num: acc_next, op: OP_NONE, last: 1'b1};
            tok_valid = 1'b1;
            acc_in    = '0;
            in_num_in = 1'b0;
         end else begin
            acc_in    = acc_next;
            in_num_in = 1'b1;
         end
      end else begin
         tok       = '{has_num: in_num_ff, num: acc_ff, op: op, last: last};
         tok_valid = in_num_ff || (op != OP_NONE) || last;
         acc_in    = '0;
         in_num_in = 1'b0;
      end
      if (!accept) begin
         tok_valid = 1'b0;
         acc_in    = acc_ff;
         in_num_in = in_num_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         in_num_ff <= 1'b0;
      end else begin
         acc_ff    <= acc_in;
         in_num_ff <= in_num_in;
      end
   end

endmodule

// File: hdl/pfe_fifo.sv
// short token queue between the front end and the stack engine
// depends on pfe_pkg
module pfe_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  pfe_pkg::token_type  wr_tok,
   output logic                full,
   input  logic                rd_en,
   output logic                empty,
   output pfe_pkg::token_type  rd_tok
);
   import pfe_pkg::*;

   token_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   always_comb begin
      full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
      empty     = (count_ff == '0);
      rd_tok    = entry_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff + QPTR_W'(wr_en);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(rd_en);
      count_in  = count_ff + (QPTR_W+1)'(wr_en) - (QPTR_W+1)'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_tok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) full |-> !wr_en)
      else $error("token queue overrun");
   assert property (@(posedge clock) disable iff (reset) empty |-> !rd_en)
      else $error("token queue underrun");
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_W+1)'(QUEUE_DEPTH))
      else $error("token queue count out of range");

endmodule

// File: hdl/pfe_div.sv
// iterative signed divider, one quotient bit per cycle, truncates toward zero
// depends on pfe_pkg; divisor zero gives quotient zero
module pfe_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [pfe_pkg::DATA_W-1:0] dividend,
   input  logic [pfe_pkg::DATA_W-1:0] divisor,
   output logic                       done,
   output logic [pfe_pkg::DATA_W-1:0] quotient
);
   import pfe_pkg::*;

   localparam int CNT_W = $clog2(DATA_W);

   logic              busy_ff, busy_in, done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] q_ff, q_in, d_ff, d_in;
   logic [DATA_W:0]   rem_ff, rem_in, rem_shift, rem_sub;
   logic              neg_ff, neg_in, zero_ff, zero_in;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      q_in      = q_ff;
      d_in      = d_ff;
      rem_in    = rem_ff;
      neg_in    = neg_ff;
      zero_in   = zero_ff;
      rem_shift = {rem_ff[DATA_W-1:0], q_ff[DATA_W-1]};
      rem_sub   = rem_shift - {1'b0, d_ff};
      if (start) begin
         q_in    = dividend[DATA_W-1] ? -dividend : dividend;
         d_in    = divisor[DATA_W-1] ? -divisor : divisor;
         neg_in  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
         zero_in = (divisor == '0);
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!rem_sub[DATA_W]) begin
            rem_in = rem_sub;
            q_in   = {q_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift;
            q_in   = {q_ff[DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DATA_W-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      done     = done_ff;
      quotient = zero_ff ? '0 : (neg_ff ? -q_ff : q_ff);
   end

   always_ff @(posedge clock) begin
      q_ff    <= q_in;
      d_ff    <= d_in;
      rem_ff  <= rem_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      cnt_ff  <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

// File: hdl/pfe_back.sv
// stack engine: pops tokens, runs the operand stack memory, alu and divider,
// holds the result register; depends on pfe_pkg and pfe_div
module pfe_back #(
   parameter int STACK_DEPTH = 128
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       tok_empty,
   input  pfe_pkg::token_type         tok,
   output logic                       tok_pop,
   output logic                       out_empty,
   input  logic                       out_pop,
   output logic [pfe_pkg::DATA_W-1:0] out_value,
   output logic [1:0]                 out_status
);
   import pfe_pkg::*;

   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_NUM   = 10'b0000000010,
      S_RDT   = 10'b0000000100,
      S_RDS   = 10'b0000001000,
      S_CALC  = 10'b0000010000,
      S_EXEC  = 10'b0000100000,
      S_DIVW  = 10'b0001000000,
      S_PUSHR = 10'b0010000000,
      S_RDV   = 10'b0100000000,
      S_EMIT  = 10'b1000000000
   } state_type;

   state_type         state_ff, state_in;
   token_type         tok_ff, tok_in;
   logic [CNT_W-1:0]  count_ff, count_in, count_dec;
   logic              err_ff, err_in;
   logic              none_ff, none_in;
   logic [DATA_W-1:0] t_ff, t_in, s_ff, s_in, r_ff, r_in;
   logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
   logic [DATA_W-1:0] rd_q_ff;
   logic              wr_en, rd_en, can_push, has_top;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [DATA_W-1:0] wr_data, popped;
   logic              out_valid_ff, out_valid_in, out_load;
   logic [DATA_W-1:0] out_value_ff, out_value_in;
   logic [1:0]        out_status_ff, out_status_in;
   logic              div_start, div_done;
   logic [DATA_W-1:0] div_q;

   pfe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (s_ff),
      .divisor  (t_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      count_dec = count_ff - 1'b1;
      can_push  = (count_ff < CNT_W'(STACK_DEPTH));
      has_top   = (count_ff != '0);
      wr_addr   = count_ff[ADDR_W-1:0];
      rd_addr   = count_dec[ADDR_W-1:0];
      popped    = none_ff ? EMPTY_VALUE : rd_q_ff;
      state_in  = state_ff;
      tok_in    = tok_ff;
      count_in  = count_ff;
      err_in    = err_ff;
      none_in   = none_ff;
      t_in      = t_ff;
      s_in      = s_ff;
      r_in      = r_ff;
      wr_en     = 1'b0;
      wr_data   = r_ff;
      rd_en     = 1'b0;
      tok_pop   = 1'b0;
      div_start = 1'b0;
      out_load  = 1'b0;
      out_valid_in  = out_valid_ff && !out_pop;
      out_value_in  = out_value_ff;
      out_status_in = out_status_ff;
      case (state_ff)
         S_IDLE: begin
            if (!tok_empty) begin
               tok_pop = 1'b1;
               tok_in  = tok;
               if (tok.has_num)              state_in = S_NUM;
               else if (tok.op != OP_NONE)   state_in = S_RDT;
               else                          state_in = S_RDV;
            end
         end
         S_NUM: begin
            // full stack drops the operand
            if (can_push) begin
               wr_en    = 1'b1;
               wr_data  = tok_ff.num;
               count_in = count_ff + 1'b1;
            end
            if (tok_ff.op != OP_NONE)  state_in = S_RDT;
            else if (tok_ff.last)      state_in = S_RDV;
            else                       state_in = S_IDLE;
         end
         S_RDT: begin
            none_in = !has_top;
            if (has_top) begin
               rd_en    = 1'b1;
               count_in = count_dec;
            end
            state_in = S_RDS;
         end
         S_RDS: begin
            t_in    = popped;
            none_in = !has_top;
            if (has_top) begin
               rd_en    = 1'b1;
               count_in = count_dec;
            end
            state_in = S_CALC;
         end
         S_CALC: begin
            s_in     = popped;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            case (tok_ff.op)
               OP_ADD:  r_in = s_ff + t_ff;
               OP_SUB:  r_in = s_ff - t_ff;
               OP_MUL:  r_in = s_ff * t_ff;
               default: r_in = r_ff;
            endcase
            if (tok_ff.op == OP_DIV) begin
               div_start = 1'b1;
               if (t_ff == '0) err_in = 1'b1;
               state_in = S_DIVW;
            end else begin
               state_in = S_PUSHR;
            end
         end
         S_DIVW: begin
            if (div_done) begin
               r_in     = div_q;
               state_in = S_PUSHR;
            end
         end
         S_PUSHR: begin
            if (can_push) begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
            end
            state_in = tok_ff.last ? S_RDV : S_IDLE;
         end
         S_RDV: begin
            none_in = !has_top;
            if (has_top) rd_en = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            // wait for room in the result register
            if (!out_valid_ff || out_pop) begin
               out_load      = 1'b1;
               out_valid_in  = 1'b1;
               out_value_in  = popped;
               out_status_in = err_ff ? STATUS_DIVZERO :
                               (count_ff > CNT_W'(1)) ? STATUS_LEFTOVER : STATUS_OK;
               count_in      = '0;
               err_in        = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      out_empty  = !out_valid_ff;
      out_value  = out_value_ff;
      out_status = out_status_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= stack_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      tok_ff        <= tok_in;
      none_ff       <= none_in;
      t_ff          <= t_in;
      s_ff          <= s_in;
      r_ff          <= r_in;
      out_value_ff  <= out_value_in;
      out_status_ff <= out_status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         err_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");
   assert property (@(posedge clock) disable iff (reset)
      out_load |=> (count_ff == '0) && !err_ff && out_valid_ff)
      else $error("engine not cleared after result");
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIVW))
      else $error("divider finished outside divide wait");
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !rd_en)
      else $error("stack push and pop in one cycle");

endmodule

// File: hdl/postfix_expression_evaluator_top.sv
// Postfix expression evaluator, one ASCII character per request.
// Request side is a queue: drive req_character/req_last with req_push while
// req_full is low. Result side is a queue: a result sits on rsp_value and
// rsp_status while rsp_empty is low and is taken with rsp_pop.
// One result comes out for each request marked req_last, in order.
// The front end takes one request per cycle while req_full is low, into a
// four-entry token queue, so a burst of up to four tokens enters back to back.
// The stack engine then takes each token in turn: an operand is pushed, an
// operator pops two entries, is applied and pushes its result, / waiting on
// the 32-step iterative divider, and end of expression reads the top and waits
// for room in the result register. Digits and ignored characters make no token
// and cost the engine nothing, unless marked req_last or ending an operand. A
// result follows the queued work ahead of it. A stalled receiver holds one
// result in the output register; the engine then waits, the token queue fills
// and req_full rises.
// Synchronous reset empties the stack, the queues and the result register.
// depends on pfe_pkg, pfe_front, pfe_fifo, pfe_back
module postfix_expression_evaluator_top #(
   parameter int STACK_DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_character,
   input  logic        req_last,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_value,
   output logic [1:0]  rsp_status
);
   import pfe_pkg::*;

   logic      accept, tok_valid, q_full, q_empty, q_pop;
   token_type front_tok, q_tok;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   pfe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .character (req_character),
      .last      (req_last),
      .tok_valid (tok_valid),
      .tok       (front_tok)
   );

   pfe_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (tok_valid),
      .wr_tok (front_tok),
      .full   (q_full),
      .rd_en  (q_pop),
      .empty  (q_empty),
      .rd_tok (q_tok)
   );

   pfe_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .tok_empty  (q_empty),
      .tok        (q_tok),
      .tok_pop    (q_pop),
      .out_empty  (rsp_empty),
      .out_pop    (rsp_pop),
      .out_value  (rsp_value),
      .out_status (rsp_status)
   );

endmodule

// File: dv/tb_postfix_expression_evaluator_top.sv
// testbench for the postfix expression evaluator top level
// drives character requests, predicts each result in-line and checks it
// depends on pfe_pkg and postfix_expression_evaluator_top
module tb_postfix_expression_evaluator_top;
   import pfe_pkg::*;

   localparam int DEPTH     = 128;
   localparam int MAX_CYCLE = 2000000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_push = 0;
   logic        req_full;
   logic [7:0]  req_character = 8'd0;
   logic        req_last = 0;
   logic        rsp_empty;
   logic        rsp_pop = 0;
   logic [31:0] rsp_value;
   logic [1:0]  rsp_status;

   postfix_expression_evaluator_top #(.STACK_DEPTH(DEPTH)) u_top (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_character(req_character), .req_last(req_last),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_value(rsp_value), .rsp_status(rsp_status)
   );

   // predictor state
   logic [31:0] calc_stack [DEPTH];
   int          calc_count = 0;
   logic [31:0] calc_acc = 0;
   bit          calc_in_num = 0;
   bit          calc_div_err = 0;

   logic [31:0] exp_value_q [$];
   logic [1:0]  exp_status_q [$];

   int  errors = 0;
   int  cycle = 0;
   bit  idle_on = 1;

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > MAX_CYCLE) begin
         $display("timeout at %0t", $time);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic void calc_push(logic [31:0] v);
      if (calc_count < DEPTH) begin
         calc_stack[calc_count] = v;
         calc_count++;
      end
   endfunction

   function automatic logic [31:0] calc_pop();
      if (calc_count == 0) return EMPTY_VALUE;
      calc_count--;
      return calc_stack[calc_count];
   endfunction

   function automatic logic [31:0] trunc_quotient(logic [31:0] s, logic [31:0] t);
      logic [31:0] sm, tm, q;
      sm = s[31] ? -s : s;
      tm = t[31] ? -t : t;
      if (tm == 0) return 0;
      q = sm / tm;
      return (s[31] != t[31]) ? -q : q;
   endfunction

   function automatic void evaluate_char(logic [7:0] c, bit lst);
      logic [31:0] t, s, r;
      logic [1:0]  st;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         calc_acc = calc_in_num ? calc_acc * 10 + (c - CH_ZERO) : 32'(c - CH_ZERO);
         calc_in_num = 1;
      end else begin
         if (calc_in_num) begin
            calc_push(calc_acc);
            calc_in_num = 0;
            calc_acc = 0;
         end
         if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) begin
            t = calc_pop();
            s = calc_pop();
            case (c)
               CH_PLUS:  r = s + t;
               CH_MINUS: r = s - t;
               CH_STAR:  r = s * t;
               default: begin
                  if (t == 0) calc_div_err = 1;
                  r = trunc_quotient(s, t);
               end
            endcase
            calc_push(r);
         end
      end
      if (!lst) return;
      if (calc_in_num) calc_push(calc_acc);
      st = calc_div_err ? STATUS_DIVZERO : (calc_count > 1 ? STATUS_LEFTOVER : STATUS_OK);
      exp_value_q.push_back(calc_count > 0 ? calc_stack[calc_count-1] : EMPTY_VALUE);
      exp_status_q.push_back(st);
      calc_count = 0;
      calc_acc = 0;
      calc_in_num = 0;
      calc_div_err = 0;
   endfunction

   // result side: random pop stalls, check on accept
   initial begin
      int gap;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 9);
            rsp_pop <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (exp_value_q.size() == 0) begin
            $display("%0t: unexpected result value %h status %0d", $time, rsp_value,
                     rsp_status);
            errors++;
         end else begin
            if (rsp_value !== exp_value_q[0]) begin
               $display("%0t: value expected %h actual %h", $time, exp_value_q[0],
                        rsp_value);
               errors++;
            end
            if (rsp_status !== exp_status_q[0]) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        exp_status_q[0], rsp_status);
               errors++;
            end
            void'(exp_value_q.pop_front());
            void'(exp_status_q.pop_front());
         end
      end
   end

   task automatic send_char(logic [7:0] c, bit lst);
      if (idle_on && $urandom_range(0, 9) == 0) begin
         req_push <= 0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_push <= 1;
      req_character <= c;
      req_last <= lst;
      @(posedge clock);
      while (req_full) @(posedge clock);
      evaluate_char(c, lst);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   task automatic test_directed();
      send_text("3 4+");
      send_text("10 3-");
      send_text("6 7*");
      send_text("7 2/");
      send_text("-7 2/");
      send_text("7 0/");
      send_text("+");
      send_text("1 2 3");
      send_text("4294967295 1+");
      send_text("2147483648 1 0-/");
      send_text("99999999999");
      send_text("12a3b+");
      send_text("5 0/ 3");
      send_char(8'hFF, 1);
      send_char(8'h00, 1);
      send_text("42");
   endtask

   task automatic test_overflow_stack();
      for (int i = 0; i < DEPTH + 4; i++) begin
         send_char(CH_ZERO + 8'(i % 10), 0);
         send_char(" ", 0);
      end
      send_char(CH_PLUS, 1);
   endtask

   function automatic logic [7:0] pick_op();
      case ($urandom_range(0, 3))
         0: return CH_PLUS;
         1: return CH_MINUS;
         2: return CH_STAR;
         default: return CH_SLASH;
      endcase
   endfunction

   // mostly well-formed expressions with random operands, some noise
   task automatic test_random(int n_items);
      int sent, depth, ndig;
      sent = 0;
      while (sent < n_items) begin
         depth = 0;
         repeat ($urandom_range(1, 8)) begin
            if (depth >= 2 && $urandom_range(0, 2) == 0) begin
               send_char(pick_op(), 0);
               depth--;
               sent++;
            end else begin
               ndig = $urandom_range(1, 11);
               repeat (ndig) begin
                  send_char(CH_ZERO + 8'($urandom_range(0, 9)), 0);
                  sent++;
               end
               send_char(" ", 0);
               sent++;
               depth++;
            end
            if ($urandom_range(0, 15) == 0) begin
               send_char(8'($urandom_range(0, 255)), 0);
               sent++;
            end
         end
         while (depth > 1 && $urandom_range(0, 5) != 0) begin
            send_char(pick_op(), 0);
            depth--;
            sent++;
         end
         send_char($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255)) : pick_op(), 1);
         sent++;
      end
   endtask

   initial begin
      int wait_cyc;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_overflow_stack();
      test_random(1000);
      idle_on = 0;
      test_random(400);
      req_push <= 0;
      wait_cyc = 0;
      while (exp_value_q.size() != 0 && wait_cyc < 200000) begin
         @(posedge clock);
         wait_cyc++;
      end
      repeat (100) @(posedge clock);
      if (errors == 0 && exp_value_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
